// ===== design/cbc_pkg.sv =====
// Shared types, constants and helpers for the cartridge bank controller.
// Used by cbc_ram and cartridge_bank_controller; depends on nothing else.
package cbc_pkg;

  localparam int RAM_BANKS  = 4;
  localparam int BANK_BYTES = 8192;
  localparam int RAM_DEPTH  = RAM_BANKS * BANK_BYTES;
  localparam int RAM_AW     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
  localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
  localparam logic [2:0] REGION_RAM_BANK   = 3'd2;
  localparam logic [2:0] REGION_RAM        = 3'd5;

  localparam logic       CMD_READ  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] UNMAPPED_BYTE  = 8'hFF;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_read;
    logic [20:0] rom_address;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  function automatic logic [1:0] bank_fold(input logic [1:0] bank);
    logic [2:0] r;
    r = {1'b0, bank};
    for (int i = 0; i < 3; i++) begin
      if (r >= 3'(RAM_BANKS)) r = r - 3'(RAM_BANKS);
    end
    return r[1:0];
  endfunction

endpackage

// ===== design/cbc_ram.sv =====
// External cartridge RAM: one synchronous port, registered read data.
// Depends on cbc_pkg for the request struct and the depth.
module cbc_ram
  import cbc_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.en && req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && !req.we) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== design/cartridge_bank_controller.sv =====
// Top level of the cartridge bank controller: bank registers, RAM access, output stage.
// Depends on cbc_pkg and cbc_ram.
//
// Usage:
//   A request (command, address, data) enters on req_valid/req_stall; one
//   response (read_data, rom_read, rom_address) leaves on rsp_valid/rsp_stall
//   for every request, in order.
//   Writes update the RAM-enable flag, ROM bank, RAM bank or clock-select
//   flag, or store a byte in the cartridge RAM. ROM reads return a translated
//   ROM address for an external ROM; RAM reads return the stored byte.
//   From acceptance to rsp_valid a request passes the middle stage, with the
//   synchronous RAM read, and then the output register. Throughput is one
//   request per cycle while rsp_stall is low, set by the single RAM port,
//   which takes either the read or the write of each request.
//   Reset clears the flags, sets the ROM bank to 1 and empties the pipeline;
//   RAM contents are undefined until written.
//   When rsp_stall is high the output holds; the middle stage keeps taking
//   one more request, and req_stall rises once both stages are full.
module cartridge_bank_controller
  import cbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic       ram_enable;
  logic [6:0] rom_bank;
  logic [1:0] ram_bank;
  logic       clock_selected;

  logic       accept;
  logic [2:0] region;
  logic [7:0] bank_value;
  ram_req_t   ram_req;
  logic [7:0] ram_q;

  logic       s1_valid;
  logic       s1_ram;
  rsp_t       s1_rsp;
  rsp_t       s1_rsp_next;
  rsp_t       s1_out;
  logic       out_free;

  assign region    = req.address[15:13];
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !out_free;
  assign accept    = req_valid && !req_stall;
  assign bank_value = (req.data == 8'd0) ? 8'd1 : req.data;

  always_comb begin
    ram_req.en    = accept && (region == REGION_RAM)
                    && ((req.command == CMD_READ) || (ram_enable && !clock_selected));
    ram_req.we    = (req.command == CMD_WRITE);
    ram_req.addr  = RAM_AW'({bank_fold(ram_bank), req.address[12:0]});
    ram_req.wdata = req.data;
  end

  cbc_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable     <= 1'b0;
      rom_bank       <= 7'd1;
      ram_bank       <= 2'd0;
      clock_selected <= 1'b0;
    end else if (accept && req.command == CMD_WRITE) begin
      case (region)
        REGION_RAM_ENABLE: ram_enable <= (req.data[3:0] == RAM_ENABLE_KEY);
        REGION_ROM_BANK:   rom_bank   <= bank_value[6:0];
        REGION_RAM_BANK: begin
          if (req.data <= 8'd3) begin
            ram_bank       <= req.data[1:0];
            clock_selected <= 1'b0;
          end
          if (req.data inside {[8'd8:8'd12]}) begin
            clock_selected <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_rsp_next = '0;
    if (req.command == CMD_READ) begin
      if (!req.address[15]) begin
        s1_rsp_next.rom_read    = 1'b1;
        s1_rsp_next.rom_address = {(req.address[14] ? rom_bank : 7'd0), req.address[13:0]};
      end else if (region != REGION_RAM) begin
        s1_rsp_next.read_data = UNMAPPED_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || req_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ram <= (req.command == CMD_READ) && (region == REGION_RAM);
      s1_rsp <= s1_rsp_next;
    end
  end

  always_comb begin
    s1_out = s1_rsp;
    if (s1_ram) begin
      s1_out.read_data = ram_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      rsp <= s1_out;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && rsp_valid))
    else $error("request stalled with a free stage");

  a_rom_bank_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_WRITE && region == REGION_ROM_BANK && req.data == 8'd0)
    |=> (rom_bank == 7'd1))
    else $error("ROM bank 0 not mapped to 1");

  a_ram_write_blocked: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_WRITE && region == REGION_RAM
     && (!ram_enable || clock_selected)) |-> !ram_req.en)
    else $error("RAM write issued while disabled");

  a_enable_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_WRITE && region == REGION_RAM_ENABLE)
    |=> (ram_enable == ($past(req.data[3:0]) == RAM_ENABLE_KEY)))
    else $error("RAM enable flag not updated");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_rsp) && $stable(ram_q)))
    else $error("held stage changed");
`endif

endmodule

// ===== tb/cartridge_bank_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cartridge_bank_controller: directed and random bus requests,
// checked against a local bank and RAM predictor. Depends on cbc_pkg and the design files.
module cartridge_bank_controller_tb;
  import cbc_pkg::*;

  localparam int NUM_RANDOM = 400;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    req_t rq;
    bit   fixed;
    rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  logic       sh_ram_en = 1'b0;
  logic [6:0] sh_rom_bank = 7'd1;
  logic [1:0] sh_ram_bank = 2'd0;
  logic       sh_clock_sel = 1'b0;
  logic [7:0] cart_ram [RAM_DEPTH];
  bit         ram_written [RAM_DEPTH];
  logic [RAM_AW-1:0] stored_idx[$];

  rsp_t      pending_rsp[$];
  plan_row_t plan[$];
  rsp_t      head_rsp;
  int        fail_count = 0;
  int        mismatch_count = 0;
  bit        tx_idle_on = 1'b0;
  bit        rx_idle_on = 1'b0;
  bit        hold_output = 1'b0;

  cartridge_bank_controller uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic rsp_t decode_access(input req_t r);
    rsp_t o;
    int unsigned idx;
    o = '0;
    idx = (int'(sh_ram_bank) % RAM_BANKS) * BANK_BYTES + int'(r.address[12:0]);
    if (r.command == CMD_WRITE) begin
      if (r.address <= 16'h1FFF) begin
        sh_ram_en = (r.data[3:0] == RAM_ENABLE_KEY);
      end else if (r.address <= 16'h3FFF) begin
        sh_rom_bank = (r.data == 8'h00) ? 7'd1 : r.data[6:0];
      end else if (r.address <= 16'h5FFF) begin
        if (r.data <= 8'h03) begin
          sh_ram_bank = r.data[1:0];
          sh_clock_sel = 1'b0;
        end else if (r.data >= 8'h08 && r.data <= 8'h0C) begin
          sh_clock_sel = 1'b1;
        end
      end else if (r.address >= 16'hA000 && r.address <= 16'hBFFF) begin
        if (sh_ram_en && !sh_clock_sel) begin
          cart_ram[idx] = r.data;
          if (!ram_written[idx]) begin
            ram_written[idx] = 1'b1;
            stored_idx.push_back(RAM_AW'(idx));
          end
        end
      end
    end else begin
      if (r.address <= 16'h3FFF) begin
        o.rom_read = 1'b1;
        o.rom_address = 21'(r.address);
      end else if (r.address <= 16'h7FFF) begin
        o.rom_read = 1'b1;
        o.rom_address = {sh_rom_bank, r.address[13:0]};
      end else if (r.address >= 16'hA000 && r.address <= 16'hBFFF) begin
        o.read_data = cart_ram[idx];
      end else begin
        o.read_data = UNMAPPED_BYTE;
      end
    end
    return o;
  endfunction

  function automatic req_t pick_request();
    req_t r;
    int unsigned sel;
    logic [RAM_AW-1:0] idx;
    sel = $urandom_range(0, 99);
    r.command = CMD_WRITE;
    r.address = 16'($urandom);
    r.data = 8'($urandom);
    if (sel < 10) begin
      r.command = CMD_READ;
      r.address = 16'($urandom_range(16'h0000, 16'h3FFF));
    end else if (sel < 25) begin
      r.command = CMD_READ;
      r.address = 16'($urandom_range(16'h4000, 16'h7FFF));
    end else if (sel < 45 && stored_idx.size() != 0) begin
      idx = stored_idx[$urandom_range(0, stored_idx.size() - 1)];
      if (int'(idx) / BANK_BYTES == int'(sh_ram_bank) % RAM_BANKS) begin
        r.command = CMD_READ;
        r.address = 16'hA000 + 16'(int'(idx) % BANK_BYTES);
      end else begin
        r.address = 16'h4000;
        r.data = 8'(int'(idx) / BANK_BYTES);
      end
    end else if (sel < 65) begin
      r.address = 16'hA000 | (r.address & 16'h1FFF);
    end else if (sel < 72) begin
      r.address = 16'($urandom_range(16'h0000, 16'h1FFF));
      if ($urandom_range(0, 9) < 7) r.data[3:0] = RAM_ENABLE_KEY;
    end else if (sel < 80) begin
      r.address = 16'($urandom_range(16'h2000, 16'h3FFF));
      case ($urandom_range(0, 3))
        0: r.data = 8'h00;
        1: r.data = 8'h80;
        default: ;
      endcase
    end else if (sel < 88) begin
      r.address = 16'($urandom_range(16'h4000, 16'h5FFF));
      if (sel < 86) r.data = 8'($urandom_range(0, 13));
    end else if (sel < 92) begin
      r.address = 16'($urandom_range(16'h6000, 16'h7FFF));
    end else begin
      r.command = 1'($urandom);
      if ($urandom_range(0, 1) != 0) r.address = 16'($urandom_range(16'h8000, 16'h9FFF));
      else r.address = 16'($urandom_range(16'hC000, 16'hFFFF));
    end
    return r;
  endfunction

  function automatic void add_step(input logic cmd, input logic [15:0] a, input logic [7:0] d,
                                   input bit fixed = 1'b0, input rsp_t want = '0);
    plan_row_t p;
    p.rq.command = cmd;
    p.rq.address = a;
    p.rq.data = d;
    p.fixed = fixed;
    p.want = want;
    plan.push_back(p);
  endfunction

  task automatic issue(input req_t r, input bit fixed, input rsp_t want);
    rsp_t predicted;
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = decode_access(r);
    pending_rsp.push_back(fixed ? want : predicted);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  initial begin
    rsp_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_output) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_output = 1'b0;
        @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        rsp_stall <= 1'b0;
        @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected response: read_data %h rom_read %b rom_address %h",
                   rsp.read_data, rsp.rom_read, rsp.rom_address);
      end else begin
        head_rsp = pending_rsp.pop_front();
        if (rsp.read_data !== head_rsp.read_data || rsp.rom_read !== head_rsp.rom_read ||
            rsp.rom_address !== head_rsp.rom_address) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: read_data exp %h got %h, rom_read exp %b got %b, %s %h got %h",
                     head_rsp.read_data, rsp.read_data, head_rsp.rom_read, rsp.rom_read,
                     "rom_address exp", head_rsp.rom_address, rsp.rom_address);
        end
      end
    end
  end

  initial begin
    req_valid <= 1'b0;
    req <= '0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_step(CMD_READ,  16'h0000, 8'h00, 1'b1, '{8'h00, 1'b1, 21'h000000});
    add_step(CMD_READ,  16'h3FFF, 8'hFF, 1'b1, '{8'h00, 1'b1, 21'h003FFF});
    add_step(CMD_READ,  16'h4000, 8'h00, 1'b1, '{8'h00, 1'b1, 21'h004000});
    add_step(CMD_READ,  16'h8000, 8'h00, 1'b1, '{UNMAPPED_BYTE, 1'b0, 21'h000000});
    add_step(CMD_READ,  16'hFFFF, 8'hFF, 1'b1, '{UNMAPPED_BYTE, 1'b0, 21'h000000});
    add_step(CMD_WRITE, 16'hA000, 8'h55, 1'b1, '{8'h00, 1'b0, 21'h000000});
    add_step(CMD_WRITE, 16'h0000, 8'h1A, 1'b1, '{8'h00, 1'b0, 21'h000000});
    add_step(CMD_WRITE, 16'hBFFF, 8'h55);
    add_step(CMD_READ,  16'hBFFF, 8'h00);
    add_step(CMD_WRITE, 16'h2000, 8'h00);
    add_step(CMD_READ,  16'h7FFF, 8'h00, 1'b1, '{8'h00, 1'b1, 21'h007FFF});
    add_step(CMD_WRITE, 16'h3FFF, 8'h80);
    add_step(CMD_READ,  16'h5000, 8'h00);
    add_step(CMD_WRITE, 16'h2000, 8'hFF);
    add_step(CMD_READ,  16'h7FFF, 8'h00, 1'b1, '{8'h00, 1'b1, 21'h1FFFFF});
    add_step(CMD_WRITE, 16'h4000, 8'h03);
    add_step(CMD_WRITE, 16'hA000, 8'hAA);
    add_step(CMD_WRITE, 16'h5FFF, 8'h08);
    add_step(CMD_WRITE, 16'hA000, 8'h11);
    add_step(CMD_READ,  16'hA000, 8'h00);
    add_step(CMD_WRITE, 16'h4000, 8'h0C);
    add_step(CMD_WRITE, 16'h4000, 8'h0D);
    add_step(CMD_WRITE, 16'h4000, 8'h00);
    add_step(CMD_WRITE, 16'h6000, 8'hFF);
    add_step(CMD_WRITE, 16'hC000, 8'hFF);
    add_step(CMD_WRITE, 16'h1FFF, 8'h0B);
    add_step(CMD_READ,  16'hBFFF, 8'h00);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (plan[i]) issue(plan[i].rq, plan[i].fixed, plan[i].want);

    // fill the pipeline behind a held output, then drain
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_output = 1'b1;
    repeat (24) issue(pick_request(), 1'b0, '0);
    req_valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      tx_idle_on = (i < NUM_RANDOM - 60) && ((i / 50) % 3 != 2);
      rx_idle_on = (i < NUM_RANDOM - 60) && ((i / 40) % 4 != 3);
      issue(pick_request(), 1'b0, '0);
    end
    req_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== cartridge_bank_controller.f =====
design/cbc_pkg.sv
design/cbc_ram.sv
design/cartridge_bank_controller.sv
tb/cartridge_bank_controller_tb.sv
